/* hdl/rau_pkg.sv */
`default_nettype none
package rau_pkg;
    localparam int unsigned FieldWidthDefault = 16;
    localparam int unsigned ResNumWidth = 32;
    localparam int unsigned ResDenWidth = 31;
    localparam int unsigned OpWidth = 3;

    localparam logic [OpWidth-1:0] OP_ADD = 3'd0;
    localparam logic [OpWidth-1:0] OP_SUB = 3'd1;
    localparam logic [OpWidth-1:0] OP_MUL = 3'd2;
    localparam logic [OpWidth-1:0] OP_DIV = 3'd3;
    localparam logic [OpWidth-1:0] OP_CMP = 3'd4;
    localparam logic [OpWidth-1:0] OP_NEG = 3'd5;
    localparam logic [OpWidth-1:0] OP_RCP = 3'd6;
    localparam logic [OpWidth-1:0] OP_NONE = 3'd7;

    typedef struct packed {
        logic signed [ResNumWidth-1:0] res_num;
        logic [ResDenWidth-1:0]        res_den;
        logic                          less;
        logic                          greater;
        logic                          equal;
        logic                          div_zero;
    } t_result;
endpackage
`default_nettype wire

/* hdl/rau_if.sv */
`default_nettype none
interface rau_req_if #(
    parameter int unsigned FIELD_WIDTH = rau_pkg::FieldWidthDefault
);
    logic valid;
    logic ready;
    logic [rau_pkg::OpWidth-1:0] req_type;
    logic signed [FIELD_WIDTH-1:0] a_num;
    logic [FIELD_WIDTH-2:0] a_den;
    logic signed [FIELD_WIDTH-1:0] b_num;
    logic [FIELD_WIDTH-2:0] b_den;
    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_res_if;
    logic valid;
    logic ready;
    logic signed [rau_pkg::ResNumWidth-1:0] res_num;
    logic [rau_pkg::ResDenWidth-1:0] res_den;
    logic less;
    logic greater;
    logic equal;
    logic div_zero;
    modport source (output valid, res_num, res_den, less, greater, equal, div_zero,
                    input ready);
    modport sink (input valid, res_num, res_den, less, greater, equal, div_zero,
                  output ready);
endinterface
`default_nettype wire

/* hdl/rational_arithmetic_unit.sv */
// Rational arithmetic unit.
// A request word on i_req carries an opcode and two fractions a_num/a_den
// and b_num/b_den. The unit adds, subtracts, multiplies, divides, negates a
// or takes the reciprocal of a, and returns one result word on o_res reduced
// to lowest terms with a positive denominator; a zero numerator gives 0/1.
// A compare request sets less, greater and equal instead. A zero result
// denominator sets div_zero and the numerator comes out unreduced.
// Products are formed by shift-and-add, one multiplier bit per cycle, the
// gcd is found by the binary (Stein) method, and the two divisions by the
// gcd are restoring divisions, one quotient bit per cycle. Add, subtract
// and compare form three products; the other operations form two.
// i_req.ready is high only while the unit is idle, so a new request is
// taken only after the previous result has been handed on. The result is
// held in an output register until o_res.ready takes it; a stalled
// receiver keeps the unit from taking the next request. Reset (i_rst_n
// low, synchronous) returns the sequencer to idle and drops o_res.valid.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int unsigned FIELD_WIDTH = rau_pkg::FieldWidthDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rau_req_if.sink   i_req,
    rau_res_if.source o_res
);
    // Products fit in 2*FIELD_WIDTH bits; a sum needs one more.
    localparam int unsigned MW = 2 * FIELD_WIDTH;
    localparam int unsigned WW = MW + 1;
    localparam int unsigned CW = $clog2(WW + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_COMB = 4'd2;
    localparam logic [3:0] S_GTZ  = 4'd3;
    localparam logic [3:0] S_GSUB = 4'd4;
    localparam logic [3:0] S_DIVA = 4'd5;
    localparam logic [3:0] S_DIVB = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_MUL2 = 4'd9;

    logic [3:0] r_state, n_state;
    logic [rau_pkg::OpWidth-1:0] r_op;
    logic signed [FIELD_WIDTH-1:0] r_an, r_bn;
    logic [FIELD_WIDTH-2:0] r_ad, r_bd;
    // Multiplier: r_mc multiplicand magnitude, r_mp multiplier, r_acc product.
    logic [WW-1:0] r_mc, r_mp, r_acc;
    logic [WW-1:0] r_p1, r_p2, r_p3;  // first, second, third product
    logic [1:0] r_pidx;
    logic r_pneg;
    // Reduction registers: magnitude, denominator, gcd working pair.
    logic [WW-1:0] r_mag, r_den, r_gu, r_gv;
    logic [CW-1:0] r_shift;
    logic r_neg;
    // Divider.
    logic [WW-1:0] r_rem, r_quo;
    logic [CW-1:0] r_cnt;
    rau_pkg::t_result r_res;
    logic r_valid;

    logic [WW-1:0] w_sum;
    logic signed [WW:0] w_num_s, w_den_s;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_valid;
    assign o_res.res_num = r_res.res_num;
    assign o_res.res_den = r_res.res_den;
    assign o_res.less = r_res.less;
    assign o_res.greater = r_res.greater;
    assign o_res.equal = r_res.equal;
    assign o_res.div_zero = r_res.div_zero;

    // The shared adder.
    assign w_sum = r_acc + (r_mp[0] ? r_mc : '0);

    // Signed views of the combined numerator and denominator.
    always_comb begin
        logic signed [WW:0] p1s, p2s, p3s;
        p1s = $signed({r_p1[WW-1], r_p1});
        p2s = $signed({r_p2[WW-1], r_p2});
        p3s = $signed({r_p3[WW-1], r_p3});
        w_num_s = '0;
        w_den_s = '0;
        unique case (r_op)
            rau_pkg::OP_ADD: begin
                w_num_s = p1s + p2s;
                w_den_s = p3s;
            end
            rau_pkg::OP_SUB: begin
                w_num_s = p1s - p2s;
                w_den_s = p3s;
            end
            default: begin
                w_num_s = p1s;
                w_den_s = p3s;
            end
        endcase
    end

    // Signed product in two's complement, stored in r_p* after sign fix.
    logic [WW-1:0] w_prod;
    assign w_prod = r_pneg ? (~r_acc + WW'(1)) : r_acc;

    // Operands for product k: 0 -> (an,bd) / (an,bn) / (-an) ; etc.
    logic signed [FIELD_WIDTH:0] w_x, w_y;
    always_comb begin
        w_x = '0;
        w_y = '0;
        unique case (r_op)
            rau_pkg::OP_MUL: begin
                w_x = (r_pidx == 2'd0) ? (FIELD_WIDTH+1)'(r_an) : $signed({2'b0, r_ad});
                w_y = (r_pidx == 2'd0) ? (FIELD_WIDTH+1)'(r_bn) : $signed({2'b0, r_bd});
            end
            rau_pkg::OP_DIV: begin
                w_x = (r_pidx == 2'd0) ? (FIELD_WIDTH+1)'(r_an) : $signed({2'b0, r_ad});
                w_y = (r_pidx == 2'd0) ? $signed({2'b0, r_bd}) : (FIELD_WIDTH+1)'(r_bn);
            end
            rau_pkg::OP_NEG: begin
                w_x = (r_pidx == 2'd0) ? -(FIELD_WIDTH+1)'(r_an) : $signed({2'b0, r_ad});
                w_y = (FIELD_WIDTH+1)'(1);
            end
            rau_pkg::OP_RCP: begin
                w_x = (r_pidx == 2'd0) ? $signed({2'b0, r_ad}) : (FIELD_WIDTH+1)'(r_an);
                w_y = (FIELD_WIDTH+1)'(1);
            end
            default: begin
                w_x = (r_pidx == 2'd0) ? (FIELD_WIDTH+1)'(r_an)
                    : (r_pidx == 2'd1) ? (FIELD_WIDTH+1)'(r_bn) : $signed({2'b0, r_ad});
                w_y = (r_pidx == 2'd0) ? $signed({2'b0, r_bd}) : $signed({2'b0, r_ad});
                if (r_pidx == 2'd2) w_y = $signed({2'b0, r_bd});
            end
        endcase
    end

    logic [WW-1:0] w_xm, w_ym;
    assign w_xm = w_x[FIELD_WIDTH] ? WW'(-w_x) : WW'(w_x);
    assign w_ym = w_y[FIELD_WIDTH] ? WW'(-w_y) : WW'(w_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_MUL2;
            S_MUL2: n_state = S_MUL;
            S_MUL: begin
                if (r_cnt == '0) begin
                    if (r_pidx == 2'd2) n_state = S_COMB;
                    else n_state = S_MUL2;
                end
            end
            S_COMB: n_state = S_GTZ;
            S_GTZ: n_state = S_GSUB;
            S_GSUB: if (r_gv == '0) n_state = S_DIVA;
            S_DIVA: if (r_cnt == '0) n_state = S_DIVB;
            S_DIVB: if (r_cnt == '0) n_state = S_DONE;
            S_DONE: n_state = S_OUT;
            S_OUT: if (!r_valid || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op <= i_req.req_type;
                r_an <= i_req.a_num;
                r_ad <= i_req.a_den;
                r_bn <= i_req.b_num;
                r_bd <= i_req.b_den;
                r_pidx <= 2'd0;
                r_res <= '0;
            end
            S_MUL2: begin
                r_mc <= w_xm;
                r_mp <= w_ym;
                r_acc <= '0;
                r_pneg <= w_x[FIELD_WIDTH] ^ w_y[FIELD_WIDTH];
                r_cnt <= CW'(MW);
            end
            S_MUL: begin
                if (r_cnt == '0) begin
                    unique case (r_pidx)
                        2'd0: r_p1 <= w_prod;
                        2'd1: r_p2 <= w_prod;
                        default: r_p3 <= w_prod;
                    endcase
                    if (r_pidx == 2'd0 && r_op != rau_pkg::OP_ADD
                        && r_op != rau_pkg::OP_SUB && r_op != rau_pkg::OP_CMP) begin
                        r_pidx <= 2'd2;
                    end else begin
                        r_pidx <= r_pidx + 2'd1;
                    end
                end else begin
                    r_acc <= w_sum;
                    r_mc <= {r_mc[WW-2:0], 1'b0};
                    r_mp <= {1'b0, r_mp[WW-1:1]};
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            S_COMB: begin
                // Move the sign of the denominator to the numerator.
                logic signed [WW:0] nn, dd;
                nn = w_num_s;
                dd = w_den_s;
                if (r_op == rau_pkg::OP_CMP) begin
                    r_res.less <= $signed(r_p1) < $signed(r_p2);
                    r_res.greater <= $signed(r_p1) > $signed(r_p2);
                    r_res.equal <= (r_an == r_bn) && (r_ad == r_bd);
                end
                if (dd[WW]) begin
                    nn = -nn;
                    dd = -dd;
                end
                r_neg <= nn[WW];
                r_mag <= nn[WW] ? WW'(-nn) : WW'(nn);
                r_den <= WW'(dd);
                // A zero denominator takes a gcd of one, so the numerator
                // passes through the divisions unchanged.
                if (dd == '0) begin
                    r_gu <= WW'(1);
                end else begin
                    r_gu <= nn[WW] ? WW'(-nn) : WW'(nn);
                end
                r_gv <= WW'(dd);
                r_shift <= '0;
            end
            S_GTZ: begin
                // A zero numerator makes the denominator itself the gcd.
                if (r_gu == '0) begin
                    r_gu <= r_gv;
                    r_gv <= '0;
                end
            end
            S_GSUB: begin
                // Binary gcd: r_gu stays nonzero, the loop ends when r_gv
                // reaches zero and r_gu scaled by the common twos is the gcd.
                if (r_gv != '0) begin
                    if (r_gu[0] == 1'b0 && r_gv[0] == 1'b0) begin
                        r_gu <= r_gu >> 1;
                        r_gv <= r_gv >> 1;
                        r_shift <= r_shift + CW'(1);
                    end else if (r_gu[0] == 1'b0) begin
                        r_gu <= r_gu >> 1;
                    end else if (r_gv[0] == 1'b0) begin
                        r_gv <= r_gv >> 1;
                    end else if (r_gu >= r_gv) begin
                        r_gu <= r_gv;
                        r_gv <= (r_gu - r_gv) >> 1;
                    end else begin
                        r_gv <= (r_gv - r_gu) >> 1;
                    end
                end else begin
                    r_gu <= r_gu << r_shift;
                    r_rem <= '0;
                    r_cnt <= CW'(WW);
                end
            end
            S_DIVA, S_DIVB: begin
                if (r_cnt == '0) begin
                    if (r_state == S_DIVA) r_mag <= r_quo;
                    else r_den <= r_quo;
                    r_rem <= '0;
                    r_cnt <= CW'(WW);
                end else begin
                    logic [WW:0] sh;
                    sh = {r_rem, (r_state == S_DIVA ? r_mag[WW-1] : r_den[WW-1])};
                    if (sh >= {1'b0, r_gu}) begin
                        r_rem <= WW'(sh - {1'b0, r_gu});
                        r_quo <= {r_quo[WW-2:0], 1'b1};
                    end else begin
                        r_rem <= WW'(sh);
                        r_quo <= {r_quo[WW-2:0], 1'b0};
                    end
                    if (r_state == S_DIVA) r_mag <= {r_mag[WW-2:0], 1'b0};
                    else r_den <= {r_den[WW-2:0], 1'b0};
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            S_DONE: begin
                if (r_op != rau_pkg::OP_CMP && r_op != rau_pkg::OP_NONE) begin
                    // A zero denominator leaves the numerator unreduced.
                    r_res.res_num <= r_neg ? -rau_pkg::ResNumWidth'(r_mag)
                                           : rau_pkg::ResNumWidth'(r_mag);
                    r_res.res_den <= rau_pkg::ResDenWidth'(r_den);
                    r_res.div_zero <= (r_den == '0);
                end
            end
            default: begin
            end
        endcase
    end

    // A unit that is not idle never takes a request.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("ready while busy");
    // A held result stays put until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(r_res)) else $error("result moved");
    // Compare flags are exclusive.
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.less && o_res.greater)) else $error("less and greater");
endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// Rational unit testbench: directed corner requests, then a long stream of
// random requests with random bursts of idle on both sides of the handshake.
// Every result word is compared with a prediction made when its request
// word was accepted.

class rational_scoreboard;
    rau_pkg::t_result pending_results[$];
    int unsigned fault_count;

    function new();
        fault_count = 0;
    endfunction

    // Reduce n/d to lowest terms, or flag a zero denominator.
    static function rau_pkg::t_result reduce_fraction(longint n, longint d);
        rau_pkg::t_result r;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        bit neg;
        r = '0;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (d == 0) begin
            r.res_num = n[31:0];
            r.div_zero = 1'b1;
            return r;
        end
        neg = n < 0;
        mag = neg ? longint'(-n) : longint'(n);
        den = d;
        x = mag;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        mag = mag / x;
        den = den / x;
        r.res_num = 32'(neg ? (64'd0 - mag) : mag);
        r.res_den = den[30:0];
        return r;
    endfunction

    function void note_request(logic [2:0] op, logic signed [15:0] an_in,
                               logic [14:0] ad_in, logic signed [15:0] bn_in,
                               logic [14:0] bd_in);
        rau_pkg::t_result r;
        longint an;
        longint ad;
        longint bn;
        longint bd;
        an = an_in;
        bn = bn_in;
        ad = ad_in;
        bd = bd_in;
        r = '0;
        case (op)
            rau_pkg::OP_ADD: r = reduce_fraction(an * bd + bn * ad, ad * bd);
            rau_pkg::OP_SUB: r = reduce_fraction(an * bd - bn * ad, ad * bd);
            rau_pkg::OP_MUL: r = reduce_fraction(an * bn, ad * bd);
            rau_pkg::OP_DIV: r = reduce_fraction(an * bd, ad * bn);
            rau_pkg::OP_CMP: begin
                r.less = (an * bd) < (bn * ad);
                r.greater = (an * bd) > (bn * ad);
                r.equal = (an == bn) && (ad == bd);
            end
            rau_pkg::OP_NEG: r = reduce_fraction(-an, ad);
            rau_pkg::OP_RCP: r = reduce_fraction(ad, an);
            default: r = '0;
        endcase
        pending_results.push_back(r);
    endfunction

    function void check_result(rau_pkg::t_result got);
        rau_pkg::t_result want;
        if (pending_results.size() == 0) begin
            $error("result word with no request pending");
            fault_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.res_num !== want.res_num) begin
            $error("res_num expected %0d actual %0d", want.res_num, got.res_num);
            fault_count++;
        end
        if (got.res_den !== want.res_den) begin
            $error("res_den expected %0d actual %0d", want.res_den, got.res_den);
            fault_count++;
        end
        if (got.less !== want.less) begin
            $error("less expected %0b actual %0b", want.less, got.less);
            fault_count++;
        end
        if (got.greater !== want.greater) begin
            $error("greater expected %0b actual %0b", want.greater, got.greater);
            fault_count++;
        end
        if (got.equal !== want.equal) begin
            $error("equal expected %0b actual %0b", want.equal, got.equal);
            fault_count++;
        end
        if (got.div_zero !== want.div_zero) begin
            $error("div_zero expected %0b actual %0b", want.div_zero, got.div_zero);
            fault_count++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 2_000_000;
    localparam int unsigned RandomCount = 1630;
    localparam int unsigned DrainCycles = 400;

    logic i_clk;
    logic i_rst_n;
    rau_req_if i_req ();
    rau_res_if o_res ();

    rational_arithmetic_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req.sink),
        .o_res  (o_res.source)
    );

    rational_scoreboard board;
    int unsigned cycle_count;
    // Receiver idling stops once the quiet last part of the run begins.
    bit quiet_phase;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up if the run takes far longer than the slowest correct one.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("rational_arithmetic_unit: mismatch");
            $finish;
        end
    end

    // The receiver accepts result words, stalling in random bursts.
    initial begin
        int unsigned stall;
        o_res.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                o_res.ready <= 1'b0;
                stall = $urandom_range(1, 9);
                repeat (stall) @(posedge i_clk);
            end
            o_res.ready <= 1'b1;
            @(posedge i_clk);
            if (o_res.valid && o_res.ready) begin
                board.check_result('{o_res.res_num, o_res.res_den, o_res.less,
                                     o_res.greater, o_res.equal, o_res.div_zero});
            end
        end
    end

    // Present one request word and hold it until the handshake completes.
    task automatic send_request(logic [2:0] op, logic [15:0] an, logic [14:0] ad,
                                logic [15:0] bn, logic [14:0] bd);
        i_req.valid <= 1'b1;
        i_req.req_type <= op;
        i_req.a_num <= an;
        i_req.a_den <= ad;
        i_req.b_num <= bn;
        i_req.b_den <= bd;
        @(posedge i_clk);
        while (!i_req.ready) @(posedge i_clk);
        board.note_request(op, an, ad, bn, bd);
    endtask

    task automatic idle_sender(int unsigned cycles);
        i_req.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // A share of small denominators so that reductions are nontrivial, with
    // values near full range, random values and the occasional zero.
    function automatic logic [14:0] pick_den();
        case ($urandom_range(0, 9))
            0: return 15'd0;
            1, 2, 3: return 15'($urandom_range(1, 12));
            4, 5: return 15'h7FFF - 15'($urandom_range(0, 3));
            default: return 15'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_num();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1, 2, 3: return 16'($urandom_range(0, 24) - 12);
            4: return 16'h8000 + 16'($urandom_range(0, 2));
            5: return 16'h7FFF - 16'($urandom_range(0, 2));
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [2:0] op;
        logic [15:0] an;
        logic [15:0] bn;
        logic [14:0] ad;
        logic [14:0] bd;
        board = new();
        cycle_count = 0;
        quiet_phase = 1'b0;
        i_rst_n = 1'b0;
        i_req.valid = 1'b0;
        i_req.req_type = rau_pkg::OP_ADD;
        i_req.a_num = '0;
        i_req.a_den = '0;
        i_req.b_num = '0;
        i_req.b_den = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: each opcode but the reciprocal on extremes, a zero numerator,
        // zero denominators, division by zero, reciprocal of zero, equal
        // and merely equivalent fractions, and the unused opcode.
        send_request(rau_pkg::OP_ADD, 16'h7FFF, 15'h7FFF, 16'h7FFF, 15'h7FFF);
        send_request(rau_pkg::OP_SUB, 16'h8000, 15'h7FFF, 16'h7FFF, 15'h7FFE);
        send_request(rau_pkg::OP_MUL, 16'h8000, 15'd1, 16'h8000, 15'd1);
        send_request(rau_pkg::OP_DIV, 16'h8000, 15'h7FFF, 16'hFFFF, 15'd1);
        send_request(rau_pkg::OP_ADD, 16'd3, 15'd4, 16'hFFFD, 15'd4);
        send_request(rau_pkg::OP_ADD, 16'd1, 15'd0, 16'd1, 15'd2);
        send_request(rau_pkg::OP_MUL, 16'd5, 15'd3, 16'd2, 15'd0);
        send_request(rau_pkg::OP_DIV, 16'd5, 15'd3, 16'd0, 15'd7);
        send_request(rau_pkg::OP_DIV, 16'd6, 15'd4, 16'hFFFE, 15'd9);
        send_request(rau_pkg::OP_CMP, 16'd1, 15'd2, 16'd1, 15'd2);
        send_request(rau_pkg::OP_CMP, 16'd1, 15'd2, 16'd2, 15'd4);
        send_request(rau_pkg::OP_CMP, 16'hFFFF, 15'd2, 16'd1, 15'd3);
        send_request(rau_pkg::OP_CMP, 16'h7FFF, 15'd1, 16'h8000, 15'h7FFF);
        send_request(rau_pkg::OP_NEG, 16'h8000, 15'h7FFF, 16'h0, 15'h0);
        send_request(rau_pkg::OP_NEG, 16'd0, 15'd9, 16'h0, 15'h0);
        send_request(rau_pkg::OP_RCP, 16'hFFFA, 15'd4, 16'h0, 15'h0);
        send_request(rau_pkg::OP_RCP, 16'd0, 15'd5, 16'h0, 15'h0);
        send_request(rau_pkg::OP_NONE, 16'hFFFF, 15'h7FFF, 16'hFFFF, 15'h7FFF);
        send_request(rau_pkg::OP_SUB, 16'd0, 15'd0, 16'd0, 15'd0);

        // The sender holds back until every pending result has come.
        idle_sender(1);
        while (board.pending_results.size() != 0) @(posedge i_clk);

        for (int unsigned n = 0; n < RandomCount; n++) begin
            if (n == RandomCount - 150) quiet_phase = 1'b1;
            op = ($urandom_range(0, 49) == 0) ? rau_pkg::OP_NONE
                                              : 3'($urandom_range(0, 6));
            an = pick_num();
            bn = pick_num();
            ad = pick_den();
            bd = pick_den();
            if ($urandom_range(0, 15) == 0) begin
                bn = an;
                bd = ad;
            end
            if (!quiet_phase && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 9));
            send_request(op, an, ad, bn, bd);
        end
        i_req.valid <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (board.fault_count == 0 && board.pending_results.size() == 0) begin
            $display("rational_arithmetic_unit: match");
        end else begin
            $display("rational_arithmetic_unit: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
hdl/rau_pkg.sv
hdl/rau_if.sv
hdl/rational_arithmetic_unit.sv
tb/testbench.sv
